### src/command_line_tokenizer_macros.svh
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Checks that a condition at one clock edge implies another at the same edge.
`define CLT_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Checks that a condition at one clock edge implies another at the next edge.
`define CLT_ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

### src/clt_pkg.sv
// Shared types and constants of the command line tokenizer.
package clt_pkg;

   localparam int LINE_MAX = 256;
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX =
      COUNT_W'((LINE_MAX + 1) > 511 ? 511 : (LINE_MAX + 1));

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_BOUND   = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      logic               summary;
      logic               bound;
      logic               byte_valid;
      logic [7:0]         arg_byte;
      logic [COUNT_W-1:0] arg_total;
      logic [COUNT_W-1:0] bytes_needed;
      logic               quote_error;
   } entry_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v >= COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
   endfunction

endpackage

### src/clt_front.sv
// Front end: tracks quoting and spacing state and classifies each request.
module clt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          line_char,
   input  logic                end_of_line,
   output logic                entry_push,
   output clt_pkg::entry_type  entry
);

   logic inside_quote_ff, inside_quote_in;
   logic quote_pending_ff, quote_pending_in;
   logic space_pending_ff, space_pending_in;
   logic at_line_start_ff, at_line_start_in;
   logic [clt_pkg::COUNT_W-1:0] arg_counter_ff, arg_counter_in;
   logic [clt_pkg::COUNT_W-1:0] byte_counter_ff, byte_counter_in;

   logic iq_eff;
   logic is_quote;
   logic is_space;

   always_comb begin
      inside_quote_in  = inside_quote_ff;
      quote_pending_in = quote_pending_ff;
      space_pending_in = space_pending_ff;
      at_line_start_in = at_line_start_ff;
      arg_counter_in   = arg_counter_ff;
      byte_counter_in  = byte_counter_ff;
      entry            = '0;
      is_quote         = (line_char == clt_pkg::CH_QUOTE);
      is_space         = (line_char == clt_pkg::CH_SPACE);
      iq_eff           = inside_quote_ff ^ quote_pending_ff;
      if (end_of_line) begin
         entry.summary      = 1'b1;
         entry.arg_total    = arg_counter_ff;
         entry.bytes_needed = byte_counter_ff;
         entry.quote_error  = iq_eff;
         inside_quote_in    = 1'b0;
         quote_pending_in   = 1'b0;
         space_pending_in   = 1'b0;
         at_line_start_in   = 1'b1;
         arg_counter_in     = clt_pkg::COUNT_W'(1);
         byte_counter_in    = clt_pkg::COUNT_W'(1);
      end else if (quote_pending_ff && is_quote) begin
         quote_pending_in = 1'b0;
         entry.byte_valid = 1'b1;
         entry.arg_byte   = clt_pkg::CH_QUOTE;
         byte_counter_in  = clt_pkg::sat_inc(byte_counter_ff);
      end else begin
         quote_pending_in = 1'b0;
         inside_quote_in  = iq_eff;
         if (!(at_line_start_ff && is_space)) begin
            at_line_start_in = 1'b0;
            if (!(space_pending_ff && is_space)) begin
               if (space_pending_ff) begin
                  space_pending_in = 1'b0;
                  entry.bound      = 1'b1;
                  arg_counter_in   = clt_pkg::sat_inc(arg_counter_ff);
                  byte_counter_in  = clt_pkg::sat_inc(byte_counter_ff);
               end
               if (is_quote) begin
                  quote_pending_in = 1'b1;
               end else if (is_space && !iq_eff) begin
                  space_pending_in = 1'b1;
               end else begin
                  entry.byte_valid = 1'b1;
                  entry.arg_byte   = line_char;
                  byte_counter_in  = clt_pkg::sat_inc(byte_counter_in);
               end
            end
         end
      end
      entry_push = accept && (entry.summary || entry.bound || entry.byte_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quote_ff  <= 1'b0;
         quote_pending_ff <= 1'b0;
         space_pending_ff <= 1'b0;
         at_line_start_ff <= 1'b1;
         arg_counter_ff   <= clt_pkg::COUNT_W'(1);
         byte_counter_ff  <= clt_pkg::COUNT_W'(1);
      end else if (accept) begin
         inside_quote_ff  <= inside_quote_in;
         quote_pending_ff <= quote_pending_in;
         space_pending_ff <= space_pending_in;
         at_line_start_ff <= at_line_start_in;
         arg_counter_ff   <= arg_counter_in;
         byte_counter_ff  <= byte_counter_in;
      end
   end

endmodule

### src/clt_back.sv
// Back end: entry queue and expansion of each entry into its responses.
module clt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        entry_push,
   input  clt_pkg::entry_type          entry,
   output logic                        full,
   output logic                        empty,
   input  logic                        pop,
   output clt_pkg::kind_type           kind,
   output logic [7:0]                  arg_byte,
   output logic [clt_pkg::COUNT_W-1:0] arg_total,
   output logic [clt_pkg::COUNT_W-1:0] bytes_needed,
   output logic                        quote_error,
   output logic                        last
);

   clt_pkg::entry_type mem_ff [clt_pkg::QDEPTH];
   logic [clt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [clt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [clt_pkg::QCNT_W-1:0] count_ff, count_in;
   logic phase_ff, phase_in;

   clt_pkg::entry_type head;
   logic take;
   logic entry_done;

   assign head  = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      kind         = clt_pkg::KIND_BYTE;
      arg_byte     = '0;
      arg_total    = '0;
      bytes_needed = '0;
      quote_error  = 1'b0;
      last         = 1'b1;
      if (head.summary) begin
         kind         = clt_pkg::KIND_SUMMARY;
         arg_total    = head.arg_total;
         bytes_needed = head.bytes_needed;
         quote_error  = head.quote_error;
      end else if (head.bound && !phase_ff) begin
         kind = clt_pkg::KIND_BOUND;
         last = !head.byte_valid;
      end else begin
         arg_byte = head.arg_byte;
      end
   end

   always_comb begin
      take       = pop && !empty;
      entry_done = take && last;
      wr_ptr_in  = entry_push ? wr_ptr_ff + clt_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = entry_done ? rd_ptr_ff + clt_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + clt_pkg::QCNT_W'(entry_push)
                            - clt_pkg::QCNT_W'(entry_done);
      phase_in   = phase_ff;
      if (entry_done) begin
         phase_in = 1'b0;
      end else if (take) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### src/command_line_tokenizer.sv
// Top level of the command line tokenizer.
// The tokenizer takes one request per cycle, one character or an end-of-line
// marker, and answers with argument bytes, argument boundaries and one
// summary per line. The front end decides each request in the cycle it is
// pushed and writes at most one entry into a four-entry queue; the back end
// shows the head entry as one response, or as two responses over two pops
// when a boundary comes before a byte. Requests keep flowing at one per cycle
// as long as the queue has room, so the sustained rate is set by how fast
// responses are popped. Reset is ready at once, with no clearing pass.
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_line_char,
   input  logic                        req_end_of_line,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output clt_pkg::kind_type           rsp_kind,
   output logic [7:0]                  rsp_arg_byte,
   output logic [clt_pkg::COUNT_W-1:0] rsp_arg_total,
   output logic [clt_pkg::COUNT_W-1:0] rsp_bytes_needed,
   output logic                        rsp_quote_error,
   output logic                        rsp_last
);

   logic               accept;
   logic               entry_push;
   clt_pkg::entry_type entry;
   logic               rsp_summary;
   logic               rsp_bound;

   assign accept      = req_push && !req_full;
   assign rsp_summary = !rsp_empty && (rsp_kind == clt_pkg::KIND_SUMMARY);
   assign rsp_bound   = !rsp_empty && (rsp_kind == clt_pkg::KIND_BOUND);

   clt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .line_char   (req_line_char),
      .end_of_line (req_end_of_line),
      .entry_push  (entry_push),
      .entry       (entry)
   );

   clt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .entry_push   (entry_push),
      .entry        (entry),
      .full         (req_full),
      .empty        (rsp_empty),
      .pop          (rsp_pop),
      .kind         (rsp_kind),
      .arg_byte     (rsp_arg_byte),
      .arg_total    (rsp_arg_total),
      .bytes_needed (rsp_bytes_needed),
      .quote_error  (rsp_quote_error),
      .last         (rsp_last)
   );

   `CLT_ASSERT_IMPLY(a_full_not_empty, clock, reset, req_full, !rsp_empty)
   `CLT_ASSERT_IMPLY(a_summary_last, clock, reset, rsp_summary, rsp_last)
   `CLT_ASSERT_IMPLY(a_bound_no_counts, clock, reset, rsp_bound, rsp_arg_total == '0)
   `CLT_ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty && !req_full)

endmodule
